### hw/rtl/rtvs_pkg.sv
// Shared types and fixed constants of the rotated trilinear volume sampler.
// Used by rtvs_front, rtvs_back and the top level; depends on nothing.
package rtvs_pkg;

  localparam int QUAT_W    = 18;
  localparam int CO_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int MAT_W     = 19;
  localparam int IDX_W     = 15;
  localparam int VAL_W     = 24;
  localparam int PIX_W     = 16;
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 8;

  localparam logic [CO_W-1:0]          CO_RESET   = 4'd15;
  localparam logic signed [QUAT_W-1:0] QUAT_ONE   = 18'sd65536;
  localparam logic signed [MAT_W-1:0]  MAT_ONE    = 19'sd65536;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_W = 3'd0,
    REG_QUAT_X = 3'd1,
    REG_QUAT_Y = 3'd2,
    REG_QUAT_Z = 3'd3,
    REG_CENTRE = 3'd4
  } cfg_reg_t;

  // What the back part has to do with one queued item.
  typedef enum logic [1:0] {
    K_WRITE  = 2'd0,
    K_SAMPLE = 2'd1,
    K_RANGE  = 2'd2,
    K_NOP    = 2'd3
  } entry_kind_t;

endpackage

### hw/rtl/rotated_trilinear_volume_sampler_unit.sv
// An accepted sample passes the front pipeline, middle queue, bank reads,
// blend and result queue; voxel writes produce no result. One item per cycle
// while full is low, set by the single-port read of each of the eight voxel banks.
// Reset (rst, synchronous, active high) restores the identity rotation and a
// centre offset of 15 and empties both queues; voxel contents are not cleared.
module rotated_trilinear_volume_sampler_unit #(
  parameter int CUBE_SIDE       = 32,
  parameter int COORD_FRAC_BITS = 10,
  parameter int INTENSITY_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rtvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtvs_pkg::QUAT_W-1:0]       cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic                              opcode,
  input  logic [rtvs_pkg::IDX_W-1:0]        voxel_index,
  input  logic [rtvs_pkg::VAL_W-1:0]        voxel_value,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_x,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_y,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_z,
  output logic                              empty,
  input  logic                              pop,
  output logic [rtvs_pkg::VAL_W-1:0]        sampled_intensity,
  output logic                              range_error
);
  import rtvs_pkg::*;

  // The design is split into a front part that takes input transfers, rotates
  // the coordinate and classifies the item, and a back part that performs the
  // voxel write or the eight bank reads and the blend. A short queue between
  // them lets either side stall without holding up the other. CUBE_SIDE must
  // be a power of two so that a voxel index splits into bit fields.
  localparam int F  = COORD_FRAC_BITS;
  localparam int IB = INTENSITY_BITS;
  localparam int CB = $clog2(CUBE_SIDE);
  localparam int EW = 2 + 3 * CB + 3 * F + IB;
  localparam int OW = $clog2(OUT_DEPTH + 1);
  localparam int UW = $clog2(MID_DEPTH + 1);

  logic          accept;
  logic          mid_push, mid_pop, mid_empty, mid_full;
  logic [EW-1:0] mid_in, mid_out;
  logic [UW-1:0] front_used;

  assign accept = push && !full;

  rtvs_front #(
    .CUBE_SIDE      (CUBE_SIDE),
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .INTENSITY_BITS (INTENSITY_BITS),
    .EW             (EW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .opcode     (opcode),
    .voxel_index(voxel_index),
    .voxel_value(voxel_value),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_z    (pixel_z),
    .mid_pop    (mid_pop),
    .full       (full),
    .used       (front_used),
    .mid_push   (mid_push),
    .mid_data   (mid_in)
  );

  rtvs_fifo #(.W(EW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk      (clk),
    .rst      (rst),
    .push     (mid_push),
    .push_data(mid_in),
    .pop      (mid_pop),
    .pop_data (mid_out),
    .empty    (mid_empty),
    .full     (mid_full)
  );

  // The back part issues an item only when a slot in the result queue is
  // reserved for it; reservations count results in the blend pipeline or result queue.
  logic          out_accept;
  logic [OW-1:0] out_used;
  logic          mid_makes_result;
  entry_kind_t   mid_kind;

  assign mid_kind         = entry_kind_t'(mid_out[EW-1 -: 2]);
  assign mid_makes_result = (mid_kind == K_SAMPLE) || (mid_kind == K_RANGE);
  assign mid_pop          = !mid_empty && (out_used < OW'(OUT_DEPTH));
  assign out_accept       = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_used <= '0;
    end else begin
      out_used <= out_used + OW'(mid_pop && mid_makes_result) - OW'(out_accept);
    end
  end

  logic          res_valid, res_err;
  logic [IB-1:0] res_int;
  logic [IB:0]   out_data;
  logic          out_full;

  rtvs_back #(
    .CUBE_SIDE      (CUBE_SIDE),
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .INTENSITY_BITS (INTENSITY_BITS),
    .EW             (EW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .issue    (mid_pop),
    .entry    (mid_out),
    .res_valid(res_valid),
    .res_int  (res_int),
    .res_err  (res_err)
  );

  rtvs_fifo #(.W(IB + 1), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data({res_int, res_err}),
    .pop      (out_accept),
    .pop_data (out_data),
    .empty    (empty),
    .full     (out_full)
  );

  assign sampled_intensity = VAL_W'(out_data[IB:1]);
  assign range_error       = out_data[0];

  // The front credit count never passes the queue depth.
  assert property (@(posedge clk) disable iff (rst) front_used <= UW'(MID_DEPTH))
    else $error("front credit count exceeds queue depth");

  // Credits must keep the middle queue from overflowing.
  assert property (@(posedge clk) disable iff (rst) !(mid_push && mid_full && !mid_pop))
    else $error("push into full middle queue");

  // Reservations must keep the result queue from overflowing.
  assert property (@(posedge clk) disable iff (rst) !(res_valid && out_full && !out_accept))
    else $error("push into full result queue");

  // A range error always leaves with zero intensity.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && range_error) |-> (sampled_intensity == '0))
    else $error("range error with nonzero intensity");
endmodule

### hw/rtl/rtvs_fifo.sv
// Small register queue with registered storage and a single read address.
// Generic; depends on nothing. DEPTH must be a power of two.
module rtvs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  assign pop_data = mem[rptr];
  assign empty    = (count == '0);
  assign full     = (count == (PW+1)'(DEPTH));
endmodule

### hw/rtl/rtvs_front.sv
// Front part: configuration registers, rotation matrix, three-stage rotation
// pipeline and item classification. Depends on rtvs_pkg.
module rtvs_front #(
  parameter int CUBE_SIDE       = 32,
  parameter int COORD_FRAC_BITS = 10,
  parameter int INTENSITY_BITS  = 24,
  parameter int EW              = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rtvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtvs_pkg::QUAT_W-1:0]     cfg_data,
  input  logic                            accept,
  input  logic                            opcode,
  input  logic [rtvs_pkg::IDX_W-1:0]      voxel_index,
  input  logic [rtvs_pkg::VAL_W-1:0]      voxel_value,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_x,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_y,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_z,
  input  logic                            mid_pop,
  output logic                            full,
  output logic [$clog2(rtvs_pkg::MID_DEPTH+1)-1:0] used,
  output logic                            mid_push,
  output logic [EW-1:0]                   mid_data
);
  import rtvs_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int IB   = INTENSITY_BITS;
  localparam int CB   = $clog2(CUBE_SIDE);
  localparam int PW   = MAT_W + PIX_W;
  localparam int AW   = PW + 5;
  localparam int IW   = (3 * CB > IDX_W) ? 3 * CB : IDX_W;
  localparam int UW   = $clog2(MID_DEPTH + 1);
  localparam int POSW = AW - 1 - F;
  localparam logic signed [39:0]   ONE_Q32  = 40'sd4294967296;
  localparam logic signed [AW-1:0] RND_HALF = AW'(32768);
  localparam logic [7:0]           SIDE_M1  = 8'(CUBE_SIDE - 1);

  function automatic logic signed [MAT_W-1:0] mat_entry(input logic signed [39:0] v);
    logic signed [39:0] r;
    r = (v + 40'sd32768) >>> 16;
    if (r > 40'sd262143) begin
      r = 40'sd262143;
    end else if (r < -40'sd262144) begin
      r = -40'sd262144;
    end
    return r[MAT_W-1:0];
  endfunction

  logic signed [QUAT_W-1:0] qw, qx, qy, qz;
  logic [CO_W-1:0]          co;
  logic signed [MAT_W-1:0]  m [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      qw <= QUAT_ONE;
      qx <= '0;
      qy <= '0;
      qz <= '0;
      co <= CO_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_W: qw <= cfg_data;
        REG_QUAT_X: qx <= cfg_data;
        REG_QUAT_Y: qy <= cfg_data;
        REG_QUAT_Z: qz <= cfg_data;
        REG_CENTRE: co <= cfg_data[CO_W-1:0];
        default: ;
      endcase
    end
  end

  // Quaternion products in Q.32, one multiplier each, then the matrix register.
  logic signed [39:0] pwx, pwy, pwz, pxx, pxy, pxz, pyy, pyz, pzz;
  assign pwx = 40'(qw * qx);
  assign pwy = 40'(qw * qy);
  assign pwz = 40'(qw * qz);
  assign pxx = 40'(qx * qx);
  assign pxy = 40'(qx * qy);
  assign pxz = 40'(qx * qz);
  assign pyy = 40'(qy * qy);
  assign pyz = 40'(qy * qz);
  assign pzz = 40'(qz * qz);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        m[k] <= (k == 0 || k == 4 || k == 8) ? MAT_ONE : '0;
      end
    end else begin
      m[0] <= mat_entry(ONE_Q32 - ((pyy + pzz) <<< 1));
      m[1] <= mat_entry((pxy + pwz) <<< 1);
      m[2] <= mat_entry((pxz - pwy) <<< 1);
      m[3] <= mat_entry((pxy - pwz) <<< 1);
      m[4] <= mat_entry(ONE_Q32 - ((pxx + pzz) <<< 1));
      m[5] <= mat_entry((pwx + pyz) <<< 1);
      m[6] <= mat_entry((pwy + pxz) <<< 1);
      m[7] <= mat_entry((pyz - pwx) <<< 1);
      m[8] <= mat_entry(ONE_Q32 - ((pxx + pyy) <<< 1));
    end
  end

  // Stage 1: captured item.
  logic                    v1, op1;
  logic [IDX_W-1:0]        idx1;
  logic [IB-1:0]           val1;
  logic signed [PIX_W-1:0] p1 [3];
  // Stage 2: matrix-by-coordinate products.
  logic                    v2, op2;
  logic [IDX_W-1:0]        idx2;
  logic [IB-1:0]           val2;
  logic signed [PW-1:0]    prod [9];
  // Stage 3: row sums with the centre shift.
  logic                    v3, op3;
  logic [IDX_W-1:0]        idx3;
  logic [IB-1:0]           val3;
  logic signed [AW-1:0]    acc [3];
  logic signed [AW-1:0]    cterm;

  assign cterm = $signed(AW'(co) << (16 + F));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    op1   <= opcode;
    idx1  <= voxel_index;
    val1  <= IB'(voxel_value);
    p1[0] <= pixel_x;
    p1[1] <= pixel_y;
    p1[2] <= pixel_z;
    op2   <= op1;
    idx2  <= idx1;
    val2  <= val1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[3*i+j] <= PW'(m[3*i+j] * p1[j]);
      end
    end
    op3  <= op2;
    idx3 <= idx2;
    val3 <= val2;
    for (int i = 0; i < 3; i++) begin
      acc[i] <= AW'(prod[3*i]) + AW'(prod[3*i+1]) + AW'(prod[3*i+2]) + cterm;
    end
  end

  // Rounding, integer/fraction split and the cube bounds check.
  logic [7:0]              co2, limm1;
  logic signed [AW-1:0]    rnd [3];
  logic [POSW-1:0]         posb [3];
  logic                    oob;
  logic [IW-1:0]           idx_ext;
  entry_kind_t             kind;
  logic [CB-1:0]           cx, cy, cz;
  logic [F-1:0]            fx, fy, fz;

  assign co2   = {3'b000, co, 1'b0};
  assign limm1 = (co2 < SIDE_M1) ? co2 : SIDE_M1;

  always_comb begin
    oob = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = (acc[i] + RND_HALF) >>> 16;
      posb[i] = rnd[i][AW-2:F];
      if (rnd[i][AW-1] || posb[i] >= POSW'(limm1)) begin
        oob = 1'b1;
      end
    end
    idx_ext = IW'(idx3);
    if (!op3) begin
      kind = ((idx_ext >> (3 * CB)) == '0) ? K_WRITE : K_NOP;
      cx   = idx_ext[3*CB-1:2*CB];
      cy   = idx_ext[2*CB-1:CB];
      cz   = idx_ext[CB-1:0];
      fx   = '0;
      fy   = '0;
      fz   = '0;
    end else begin
      kind = oob ? K_RANGE : K_SAMPLE;
      cx   = posb[0][CB-1:0];
      cy   = posb[1][CB-1:0];
      cz   = posb[2][CB-1:0];
      fx   = rnd[0][F-1:0];
      fy   = rnd[1][F-1:0];
      fz   = rnd[2][F-1:0];
    end
  end

  assign mid_push = v3;
  assign mid_data = {kind, cx, cy, cz, fx, fy, fz, val3};

  // Credits cover the three pipeline stages plus the queue entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + UW'(accept) - UW'(mid_pop);
    end
  end

  assign full = (used == UW'(MID_DEPTH));
endmodule

### hw/rtl/rtvs_back.sv
// Back part: eight parity-split voxel banks and the three-stage trilinear blend.
// Depends on rtvs_pkg.
module rtvs_back #(
  parameter int CUBE_SIDE       = 32,
  parameter int COORD_FRAC_BITS = 10,
  parameter int INTENSITY_BITS  = 24,
  parameter int EW              = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      issue,
  input  logic [EW-1:0]             entry,
  output logic                      res_valid,
  output logic [INTENSITY_BITS-1:0] res_int,
  output logic                      res_err
);
  import rtvs_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int IB    = INTENSITY_BITS;
  localparam int CB    = $clog2(CUBE_SIDE);
  localparam int HB    = CB - 1;
  localparam int BAW   = 3 * HB;
  localparam int BDEP  = 1 << BAW;
  localparam int LW    = IB + F + 2;
  localparam logic [F:0] FULL = (F+1)'(1) << F;
  localparam logic [LW-1:0] HALF = LW'(1) << (F - 1);

  function automatic logic [IB-1:0] lerp(input logic [IB-1:0] a, input logic [IB-1:0] b,
                                         input logic [F-1:0] f);
    logic [LW-1:0] s;
    s = LW'(a) * LW'(FULL - (F+1)'(f)) + LW'(b) * LW'(f) + HALF;
    return s[IB+F-1:F];
  endfunction

  entry_kind_t   kind;
  logic [1:0]    kind_bits;
  logic [CB-1:0] cx, cy, cz;
  logic [F-1:0]  fx, fy, fz;
  logic [IB-1:0] dat;
  logic [2:0]    par;

  assign {kind_bits, cx, cy, cz, fx, fy, fz, dat} = entry;
  assign kind = entry_kind_t'(kind_bits);
  assign par  = {cx[0], cy[0], cz[0]};

  logic [7:0][IB-1:0] rd_all;

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic BX = b[2];
    localparam logic BY = b[1];
    localparam logic BZ = b[0];
    logic [IB-1:0]  mem [BDEP];
    logic [IB-1:0]  rdq;
    logic [CB-1:0]  ax, ay, az;
    logic [BAW-1:0] raddr;
    logic           we;

    // The bank holds the neighbor whose coordinate parity matches its own.
    assign ax    = (cx[0] == BX) ? cx : cx + 1'b1;
    assign ay    = (cy[0] == BY) ? cy : cy + 1'b1;
    assign az    = (cz[0] == BZ) ? cz : cz + 1'b1;
    assign raddr = {ax[CB-1:1], ay[CB-1:1], az[CB-1:1]};
    assign we    = issue && (kind == K_WRITE) && (par == 3'(b));

    always_ff @(posedge clk) begin
      if (we) begin
        mem[{cx[CB-1:1], cy[CB-1:1], cz[CB-1:1]}] <= dat;
      end
      rdq <= mem[raddr];
    end
    assign rd_all[b] = rdq;
  end

  logic          v1, v2, v3;
  entry_kind_t   k1, k2, k3;
  logic [2:0]    par1;
  logic [F-1:0]  fx1, fy1, fz1, fx2, fy2, fx3;
  logic [IB-1:0] zl [4];
  logic [IB-1:0] yl [2];
  logic [IB-1:0] xl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    k1   <= kind;
    par1 <= par;
    fx1  <= fx;
    fy1  <= fy;
    fz1  <= fz;
    k2   <= k1;
    fx2  <= fx1;
    fy2  <= fy1;
    for (int d = 0; d < 4; d++) begin
      zl[d] <= lerp(rd_all[{2'(d), 1'b0} ^ par1], rd_all[{2'(d), 1'b1} ^ par1], fz1);
    end
    k3  <= k2;
    fx3 <= fx2;
    yl[0] <= lerp(zl[0], zl[1], fy2);
    yl[1] <= lerp(zl[2], zl[3], fy2);
  end

  assign xl        = lerp(yl[0], yl[1], fx3);
  assign res_valid = v3 && (k3 == K_SAMPLE || k3 == K_RANGE);
  assign res_err   = (k3 == K_RANGE);
  assign res_int   = res_err ? '0 : xl;
endmodule

### tb/rtvs_checker.sv
// Scoreboard for the rotated trilinear volume sampler: predicts each sample result
// and checks what the block returns. Depends on rtvs_pkg.
`timescale 1ns / 1ps

module rtvs_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rtvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtvs_pkg::QUAT_W-1:0]       cfg_data,
  input  logic                              push,
  input  logic                              full,
  input  logic                              opcode,
  input  logic [rtvs_pkg::IDX_W-1:0]        voxel_index,
  input  logic [rtvs_pkg::VAL_W-1:0]        voxel_value,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_x,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_y,
  input  logic signed [rtvs_pkg::PIX_W-1:0] pixel_z,
  input  logic                              empty,
  input  logic                              pop,
  input  logic [rtvs_pkg::VAL_W-1:0]        sampled_intensity,
  input  logic                              range_error,
  output int                                pending,
  output int                                fail_count
);
  import rtvs_pkg::*;

  localparam int SIDE = 32;
  localparam int FRAC = 10;

  typedef struct {
    logic [VAL_W-1:0] intensity;
    logic             err;
  } sample_result_t;

  logic [VAL_W-1:0]         volume [SIDE*SIDE*SIDE];
  logic signed [MAT_W-1:0]  rot [9];
  logic signed [QUAT_W-1:0] qw, qx, qy, qz;
  logic [CO_W-1:0]          centre;
  sample_result_t           expected_samples [$];

  initial fail_count = 0;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic signed [MAT_W-1:0] round_entry(input longint q32);
    longint r;
    r = (q32 + (64'sd1 <<< 15)) >>> 16;
    if (r > 262143) r = 262143;
    if (r < -262144) r = -262144;
    return r[MAT_W-1:0];
  endfunction

  // Rotation matrix of the current quaternion, entries rounded to Q2.16.
  task automatic rebuild_rotation();
    longint w, x, y, z, one;
    w = qw; x = qx; y = qy; z = qz;
    one = 64'sd1 <<< 32;
    rot[0] = round_entry(one - 2 * (y * y + z * z));
    rot[1] = round_entry(2 * (x * y + w * z));
    rot[2] = round_entry(2 * (x * z - w * y));
    rot[3] = round_entry(2 * (x * y - w * z));
    rot[4] = round_entry(one - 2 * (x * x + z * z));
    rot[5] = round_entry(2 * (w * x + y * z));
    rot[6] = round_entry(2 * (w * y + x * z));
    rot[7] = round_entry(2 * (y * z - w * x));
    rot[8] = round_entry(one - 2 * (x * x + y * y));
  endtask

  function automatic longint blend(input longint a, input longint b, input longint f);
    return (a * ((1 << FRAC) - f) + b * f + (1 << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint voxel_at(input longint x, input longint y, input longint z);
    return longint'(volume[(x * SIDE + y) * SIDE + z]);
  endfunction

  function automatic sample_result_t predict_sample(input logic signed [PIX_W-1:0] px,
                                                    input logic signed [PIX_W-1:0] py,
                                                    input logic signed [PIX_W-1:0] pz);
    longint p [3];
    longint pos [3];
    longint fr [3];
    longint acc, t, lim, a, b, c, d, e, g;
    sample_result_t res;
    p[0] = px; p[1] = py; p[2] = pz;
    lim = 2 * longint'(centre) + 1;
    if (lim > SIDE) lim = SIDE;
    res.intensity = '0;
    res.err = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = longint'(rot[3*i]) * p[0] + longint'(rot[3*i+1]) * p[1]
          + longint'(rot[3*i+2]) * p[2] + (longint'(centre) <<< (16 + FRAC));
      t = (acc + (64'sd1 <<< 15)) >>> 16;
      pos[i] = t >>> FRAC;
      fr[i] = t & ((1 << FRAC) - 1);
      if (pos[i] < 0 || pos[i] + 1 >= lim) res.err = 1'b1;
    end
    if (res.err) return res;
    a = blend(voxel_at(pos[0], pos[1], pos[2]), voxel_at(pos[0], pos[1], pos[2] + 1), fr[2]);
    b = blend(voxel_at(pos[0], pos[1] + 1, pos[2]),
              voxel_at(pos[0], pos[1] + 1, pos[2] + 1), fr[2]);
    c = blend(voxel_at(pos[0] + 1, pos[1], pos[2]),
              voxel_at(pos[0] + 1, pos[1], pos[2] + 1), fr[2]);
    d = blend(voxel_at(pos[0] + 1, pos[1] + 1, pos[2]),
              voxel_at(pos[0] + 1, pos[1] + 1, pos[2] + 1), fr[2]);
    e = blend(a, b, fr[1]);
    g = blend(c, d, fr[1]);
    res.intensity = VAL_W'(blend(e, g, fr[0]));
    return res;
  endfunction

  always @(posedge clk) begin
    sample_result_t want;
    if (rst) begin
      qw = QUAT_ONE; qx = '0; qy = '0; qz = '0;
      centre = CO_RESET;
      rebuild_rotation();
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_QUAT_W: begin qw = cfg_data; rebuild_rotation(); end
          REG_QUAT_X: begin qx = cfg_data; rebuild_rotation(); end
          REG_QUAT_Y: begin qy = cfg_data; rebuild_rotation(); end
          REG_QUAT_Z: begin qz = cfg_data; rebuild_rotation(); end
          REG_CENTRE: centre = cfg_data[CO_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        if (opcode) expected_samples.push_back(predict_sample(pixel_x, pixel_y, pixel_z));
        else volume[voxel_index] = voxel_value;
      end
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          report($sformatf("unexpected result intensity=%0h err=%0b",
                           sampled_intensity, range_error));
        end else begin
          want = expected_samples.pop_front();
          if (range_error !== want.err)
            report($sformatf("range_error got %b want %b", range_error, want.err));
          if (sampled_intensity !== want.intensity)
            report($sformatf("sampled_intensity got %0h want %0h",
                             sampled_intensity, want.intensity));
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

### tb/tb_top.sv
// Top of the sampler testbench: clock, reset, stimulus and verdict.
// Depends on rtvs_pkg, rtvs_checker and rotated_trilinear_volume_sampler_unit.
`timescale 1ns / 1ps

module tb_top;
  import rtvs_pkg::*;

  // An index past the register map; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam int   CYCLE_LIMIT = 600000;
  localparam int   PHASES = 10;
  localparam int   ITEMS_PER_PHASE = 40;
  // Samples only ever read voxels up to twice the largest centre offset used,
  // so only that corner of the cube is filled first.
  localparam int   CENTRE_MAX = 4;
  localparam int   PRELOAD_SIDE = 2 * CENTRE_MAX + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QUAT_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic opcode = 1'b0;
  logic [IDX_W-1:0] voxel_index = '0;
  logic [VAL_W-1:0] voxel_value = '0;
  logic signed [PIX_W-1:0] pixel_x = '0, pixel_y = '0, pixel_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic [VAL_W-1:0] sampled_intensity;
  logic range_error;
  int pending, fail_count;
  int cycles = 0;
  int stall_mode = 0;
  int burst_left = 0;
  int cur_centre = 15;

  always #1 clk = ~clk;

  rotated_trilinear_volume_sampler_unit dut (.*);
  rtvs_checker checker_i (.*);

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The result side stalls on its own pattern, chosen per phase: never, at
  // random, or at random on most cycles.
  always @(negedge clk) begin
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 1);
      default: pop <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Presents one item and holds it until the block takes the transfer. The
  // full flag only moves at rising edges, so reading it at the falling edge
  // tells whether the coming edge accepts the item. Callers arrive at a
  // falling edge. Between bursts the push line is usually dropped for a random gap.
  task automatic send(input logic op, input int idx, input int val,
                      input int px, input int py, input int pz);
    logic was_full;
    push <= 1'b1;
    opcode <= op;
    voxel_index <= idx[IDX_W-1:0];
    voxel_value <= val[VAL_W-1:0];
    pixel_x <= px[PIX_W-1:0];
    pixel_y <= py[PIX_W-1:0];
    pixel_z <= pz[PIX_W-1:0];
    was_full = full;
    @(posedge clk);
    while (was_full) begin
      @(negedge clk);
      was_full = full;
      @(posedge clk);
    end
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[QUAT_W-1:0];
    @(negedge clk);
  endtask

  // Registers change only when no sample is in flight; voxel writes give no
  // result, so the task also waits for any that are still in the pipeline.
  task automatic set_config(input int w, input int x, input int y, input int z,
                            input int centre);
    push <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk);
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
    write_reg(REG_CENTRE, centre);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_centre = centre;
  endtask

  // A random unit quaternion, scaled to Q1.16.
  task automatic random_rotation(input int centre);
    real a, b, c, d, n;
    a = $itor($urandom_range(0, 2000)) - 1000.0;
    b = $itor($urandom_range(0, 2000)) - 1000.0;
    c = $itor($urandom_range(0, 2000)) - 1000.0;
    d = $itor($urandom_range(0, 2000)) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) set_config(65536, 0, 0, 0, centre);
    else set_config($rtoi(a / n * 65536.0), $rtoi(b / n * 65536.0),
                    $rtoi(c / n * 65536.0), $rtoi(d / n * 65536.0), centre);
  endtask

  function automatic int coord(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly samples that land inside the cube, some near its faces, some
  // anywhere, and a share of voxel rewrites with random content.
  task automatic random_items(input int count);
    int span, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        send(OP_WRITE, $urandom_range(0, 32767), $urandom_range(0, 24'hFFFFFF),
             $urandom, $urandom, $urandom);
      end else begin
        if (sel < 80) span = (cur_centre - 1) * 1024 * 577 / 1000;
        else if (sel < 90) span = cur_centre * 1024;
        else span = 32767;
        send(OP_SAMPLE, $urandom, $urandom, coord(span), coord(span), coord(span));
      end
    end
  endtask

  initial begin
    int edge_lo, edge_hi;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every voxel that a sample can reach gets a value first.
    stall_mode = 0;
    for (int x = 0; x < PRELOAD_SIDE; x++)
      for (int y = 0; y < PRELOAD_SIDE; y++)
        for (int z = 0; z < PRELOAD_SIDE; z++)
          send(OP_WRITE, x * 1024 + y * 32 + z, $urandom_range(0, 24'hFFFFFF), 0, 0, 0);

    // Directed items under the reset configuration (identity, centre 15).
    // In-range samples stay in the low corner that has been filled.
    edge_lo = -15 * 1024;
    edge_hi = 15 * 1024 - 1;
    send(OP_WRITE, 0, 0, 0, 0, 0);
    send(OP_WRITE, 32767, 24'hFFFFFF, 0, 0, 0);
    send(OP_WRITE, 1, 24'hFFFFFF, 0, 0, 0);
    send(OP_SAMPLE, 0, 0, edge_lo, edge_lo, edge_lo);
    send(OP_SAMPLE, 0, 0, edge_lo, edge_lo, edge_lo + 512);
    send(OP_SAMPLE, 0, 0, edge_lo + 2048, edge_lo + 1024, edge_lo + 3072);
    send(OP_SAMPLE, 0, 0, edge_lo + 8191, edge_lo + 8191, edge_lo + 8191);
    send(OP_SAMPLE, 0, 0, edge_hi + 1, 0, 0);
    send(OP_SAMPLE, 0, 0, 0, edge_lo - 1, 0);
    send(OP_SAMPLE, 0, 0, 0, 0, edge_hi + 1);
    send(OP_SAMPLE, 0, 0, 32767, 32767, 32767);
    send(OP_SAMPLE, 0, 0, -32768, -32768, -32768);
    send(OP_SAMPLE, 0, 0, edge_lo + 1023, edge_lo + 2047, edge_lo + 511);

    // Writes to an unmapped register must leave the configuration alone.
    push <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk);
    write_reg(REG_UNMAPPED, 18'h3FFFF);
    cfg_we <= 1'b0;
    @(negedge clk);
    send(OP_SAMPLE, 0, 0, edge_lo + 100, edge_lo + 200, edge_lo + 300);

    for (int ph = 0; ph < PHASES; ph++) begin
      stall_mode = ph % 3;
      case (ph)
        0: set_config(65536, 0, 0, 0, 1);
        1: set_config(46341, 46341, 0, 0, 4);
        2: set_config(0, 0, 65536, 0, 3);
        3: set_config(-65536, 0, 0, 0, 4);
        4: set_config(65536, 65536, 65536, 65536, 4);        // saturating matrix
        5: set_config(-65536, -65536, -65536, -65536, 4);
        6: set_config(0, 0, 0, -65536, 2);
        default: random_rotation($urandom_range(1, CENTRE_MAX));
      endcase
      random_items(ITEMS_PER_PHASE);
    end

    push <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    @(negedge clk);
    rst <= 1'b1;
  end

endmodule
